// ===== rtl/ptm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ptm_pkg
// shared types and constants of the pppoe offer tag matcher
// ----------------------------------------------------------------------------
package ptm_pkg;

  localparam int MAC_W       = 48;
  localparam int UNIQ_W      = 16;
  localparam int TAG_OFS_W   = 17;
  localparam int PAYLOAD_START = 20;
  localparam logic [15:0] HOST_UNIQ_TYPE = 16'h0103;
  localparam logic [15:0] HOST_UNIQ_LEN  = 16'd2;

  typedef enum logic [0:0] {
    CFG_LOCAL_MAC = 1'b0,
    CFG_HOST_UNIQ = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    V_SEARCHING = 3'b001,
    V_MATCHED   = 3'b010,
    V_REJECTED  = 3'b100
  } verdict_t;

  typedef struct packed {
    logic       go;
    logic [7:0] rx_byte;
    logic       frame_end;
  } step_t;

  typedef struct packed {
    logic             offer_match;
    logic [MAC_W-1:0] src_addr;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/ptm_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ptm_in_if
// receive byte channel: one frame byte per word
// ----------------------------------------------------------------------------
interface ptm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_end;

  modport source (output valid, output rx_byte, output frame_end, input ready);
  modport sink   (input valid, input rx_byte, input frame_end, output ready);
endinterface
`default_nettype wire

// ===== rtl/ptm_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ptm_out_if
// result channel: one word per frame
// ----------------------------------------------------------------------------
interface ptm_out_if;
  logic        valid;
  logic        ready;
  logic        offer_match;
  logic [47:0] src_addr;

  modport source (output valid, output offer_match, output src_addr, input ready);
  modport sink   (input valid, input offer_match, input src_addr, output ready);
endinterface
`default_nettype wire

// ===== rtl/ptm_tag_walker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ptm_tag_walker
// per-byte frame state: destination check, source capture, tag walk
// ----------------------------------------------------------------------------
module ptm_tag_walker #(
  parameter int MAX_FRAME_BYTES = 2048
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ptm_pkg::step_t              step,
  input  logic [ptm_pkg::MAC_W-1:0]   local_mac,
  input  logic [ptm_pkg::UNIQ_W-1:0]  uniq_key,
  output ptm_pkg::result_t            result
);
  import ptm_pkg::*;

  localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_FRAME_BYTES);

  logic [POS_W-1:0]     pos_r, pos_nxt;
  logic                 dest_equal_r, dest_equal_nxt;
  logic [MAC_W-1:0]     src_mac_r, src_mac_nxt;
  logic [15:0]          pay_len_r, pay_len_nxt;
  logic [TAG_OFS_W-1:0] tag_ofs_r, tag_ofs_nxt;
  logic [15:0]          tlv_kind_r, tlv_kind_nxt;
  logic [15:0]          tag_len_r, tag_len_nxt;
  logic [15:0]          tag_val_r, tag_val_nxt;
  verdict_t             verdict_r, verdict_nxt;

  logic [TAG_OFS_W-1:0] pos_ext;
  logic [TAG_OFS_W-1:0] tag_d;
  logic [7:0]           mac_byte;
  logic [15:0]          len_full;
  logic [15:0]          val_full;

  assign pos_ext  = TAG_OFS_W'(pos_r);
  assign tag_d    = pos_ext - tag_ofs_r;
  assign mac_byte = 8'(local_mac >> {3'd5 - pos_r[2:0], 3'b000});
  assign len_full = {tag_len_r[15:8], step.rx_byte};
  assign val_full = {tag_val_r[15:8], step.rx_byte};

  always_comb begin
    pos_nxt        = pos_r;
    dest_equal_nxt = dest_equal_r;
    src_mac_nxt    = src_mac_r;
    pay_len_nxt    = pay_len_r;
    tag_ofs_nxt    = tag_ofs_r;
    tlv_kind_nxt   = tlv_kind_r;
    tag_len_nxt    = tag_len_r;
    tag_val_nxt    = tag_val_r;
    verdict_nxt    = verdict_r;
    if (pos_r < POS_MAX) begin
      pos_nxt = pos_r + 1'b1;
      if (pos_r < POS_W'(6)) begin
        if (mac_byte != step.rx_byte) begin
          dest_equal_nxt = 1'b0;
        end
      end else if (pos_r < POS_W'(12)) begin
        src_mac_nxt = {src_mac_r[MAC_W-9:0], step.rx_byte};
      end else if (pos_r == POS_W'(18)) begin
        pay_len_nxt = {step.rx_byte, 8'h00};
      end else if (pos_r == POS_W'(19)) begin
        pay_len_nxt = {pay_len_r[15:8], step.rx_byte};
      end else if (pos_r >= POS_W'(PAYLOAD_START) && verdict_r == V_SEARCHING &&
                   pos_ext >= tag_ofs_r) begin
        case (tag_d)
          TAG_OFS_W'(0): begin
            if (tag_ofs_r - TAG_OFS_W'(PAYLOAD_START) >= TAG_OFS_W'(pay_len_r)) begin
              verdict_nxt = V_REJECTED;
            end else begin
              tlv_kind_nxt = {step.rx_byte, 8'h00};
            end
          end
          TAG_OFS_W'(1): tlv_kind_nxt = {tlv_kind_r[15:8], step.rx_byte};
          TAG_OFS_W'(2): tag_len_nxt  = {step.rx_byte, 8'h00};
          TAG_OFS_W'(3): begin
            tag_len_nxt = len_full;
            if (tlv_kind_r == HOST_UNIQ_TYPE) begin
              if (len_full != HOST_UNIQ_LEN) begin
                verdict_nxt = V_REJECTED;
              end
            end else begin
              tag_ofs_nxt = tag_ofs_r + TAG_OFS_W'(4) + TAG_OFS_W'(len_full);
            end
          end
          TAG_OFS_W'(4): tag_val_nxt = {step.rx_byte, 8'h00};
          TAG_OFS_W'(5): begin
            tag_val_nxt = val_full;
            verdict_nxt = (val_full == uniq_key) ? V_MATCHED : V_REJECTED;
          end
          default: ;
        endcase
      end
    end
  end

  assign result.offer_match = dest_equal_nxt && (verdict_nxt == V_MATCHED);
  assign result.src_addr    = src_mac_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n || (step.go && step.frame_end)) begin
      pos_r        <= '0;
      dest_equal_r <= 1'b1;
      src_mac_r    <= '0;
      pay_len_r    <= '0;
      tag_ofs_r    <= TAG_OFS_W'(PAYLOAD_START);
      tlv_kind_r   <= '0;
      tag_len_r    <= '0;
      tag_val_r    <= '0;
      verdict_r    <= V_SEARCHING;
    end else if (step.go) begin
      pos_r        <= pos_nxt;
      dest_equal_r <= dest_equal_nxt;
      src_mac_r    <= src_mac_nxt;
      pay_len_r    <= pay_len_nxt;
      tag_ofs_r    <= tag_ofs_nxt;
      tlv_kind_r   <= tlv_kind_nxt;
      tag_len_r    <= tag_len_nxt;
      tag_val_r    <= tag_val_nxt;
      verdict_r    <= verdict_nxt;
    end
  end

`ifndef SYNTH
  a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    step.go && step.frame_end |=> pos_r == '0 && verdict_r == V_SEARCHING && dest_equal_r)
    else $error("frame state not cleared after last byte");

  a_no_verdict_before_tags: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r < POS_W'(PAYLOAD_START) |-> verdict_r == V_SEARCHING)
    else $error("verdict reached before tag area");

  a_tag_ofs_floor: assert property (@(posedge clk) disable iff (!rst_n)
    tag_ofs_r >= TAG_OFS_W'(PAYLOAD_START))
    else $error("tag offset below payload start");
`endif

endmodule
`default_nettype wire

// ===== rtl/pppoe_offer_tag_matcher.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pppoe_offer_tag_matcher
// checks a received pppoe offer frame for local mac and host-uniq tag
// ----------------------------------------------------------------------------
// result: the frame_end byte passes the input register, then its result word is held in the output register
// throughput: one byte word per cycle; the last byte of a frame waits only
//   while the previous result word is still held in the output register
// reset: rst_n synchronous active low; clears config to 0, frame state, and
//   both valid flags
module pppoe_offer_tag_matcher #(
  parameter int MAX_FRAME_BYTES = 2048
) (
  input  logic                         clk,
  input  logic                         rst_n,
  ptm_in_if.sink                       in_chan,
  ptm_out_if.source                    out_chan,
  input  logic                         cfg_we,
  input  ptm_pkg::cfg_idx_t            cfg_index,
  input  logic [ptm_pkg::MAC_W-1:0]    cfg_wdata
);
  import ptm_pkg::*;

  logic [MAC_W-1:0]  local_mac_r;
  logic [UNIQ_W-1:0] uniq_key_r;

  logic              s1_valid_r;
  logic [7:0]        s1_byte_r;
  logic              s1_last_r;
  logic              s1_go;
  logic              in_acc;

  logic              out_valid_r;
  logic              out_match_r;
  logic [MAC_W-1:0]  out_peer_r;

  step_t             step;
  result_t           result;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_mac_r <= '0;
      uniq_key_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LOCAL_MAC: local_mac_r <= cfg_wdata;
        CFG_HOST_UNIQ: uniq_key_r  <= cfg_wdata[UNIQ_W-1:0];
        default: ;
      endcase
    end
  end

  assign s1_go         = s1_valid_r && (!s1_last_r || !out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || s1_go;
  assign in_acc        = in_chan.valid && in_chan.ready;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r <= in_chan.rx_byte;
      s1_last_r <= in_chan.frame_end;
    end
  end

  assign step.go        = s1_go;
  assign step.rx_byte   = s1_byte_r;
  assign step.frame_end = s1_last_r;

  ptm_tag_walker #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_walker (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .local_mac (local_mac_r),
    .uniq_key  (uniq_key_r),
    .result    (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last_r) begin
      out_match_r <= result.offer_match;
      out_peer_r  <= result.src_addr;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.offer_match = out_match_r;
  assign out_chan.src_addr    = out_peer_r;

`ifndef SYNTH
  a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_go && s1_last_r))
    else $error("result word without a last byte");

  a_stall_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_last_r && out_valid_r && !out_chan.ready |-> !in_chan.ready)
    else $error("input taken while last byte is stalled");

  a_no_result_loss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_chan.ready |-> !(s1_go && s1_last_r))
    else $error("held result word overwritten");
`endif

endmodule
`default_nettype wire
